// ===== hdl/sba_pkg.sv =====
// Shared types, constants and sequencer states for the spectrum bin auto-gain block.
package sba_pkg;

    // Default geometry of the block.
    localparam int BANDS_IN_DEF    = 122;
    localparam int COLUMNS_OUT_DEF = 23;

    // Field widths.
    localparam int LEVEL_W  = 8;
    localparam int COLUMN_W = 5;

    // Shared divider: 16-bit dividend, 8-bit divisor, one quotient bit per cycle.
    localparam int DIV_W  = 16;
    localparam int DIVR_W = 8;
    localparam int STEP_W = $clog2(DIV_W + 1);

    // Band scaling: value * (1 + SCALE_FRAC / 2^32), the integer part of the gain kept apart.
    localparam int                FRAC_W     = 29;
    localparam int                FRAC_SHIFT = 32;
    localparam logic [FRAC_W-1:0] SCALE_FRAC = 29'd269357081;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LEVEL_W-1:0] PEAK_RESET = 8'd50;

    // Input command codes.
    localparam logic CMD_BAND = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_EDIV,
        ST_EWAIT,
        ST_BIN_INIT,
        ST_BIN_WALK,
        ST_MEAN_WAIT,
        ST_MEAN_WR,
        ST_NORM_RD,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/spectrum_bin_autogain.sv =====
// Top level of the spectrum bin auto-gain block: sequencer, band and column stores, divider.
//
// Input channel (i_in_valid / o_in_stall): each beat carries i_cmd and i_band_value. A band
// beat (command zero) is scaled by about 1.0627, saturated to 255, stored and added to the
// frame energy; the input is stalled while it is stored. A tick beat (command one) lowers the
// running peak by one while it sits above the configured floor and does not stall the input.
// The beat that completes a frame of BANDS_IN bands starts the frame pass: the band store is
// walked once, column means and the mean energy are formed, the peak is raised, and then
// COLUMNS_OUT column beats and one energy beat (o_last_of_frame set) leave on the output
// channel (o_out_valid / i_out_stall). Most of the frame pass is spent in the shared
// restoring divider, which forms the mean energy, the column means and the normalised
// levels in turn.
// While the block is busy o_in_stall is high.
// The output beat sits in a register: a stalling receiver only holds the sequencer at the
// point where it wants to place the next beat, and the last beat of a frame may wait there
// while new bands are already being taken in.
// The configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the peak floor.
// A synchronous reset empties the frame, sets the peak and the floor to 50 and drops any
// pending output beat. The stores themselves are not cleared; every entry is written in a
// frame before it is read.
module spectrum_bin_autogain #(
    parameter int BANDS_IN    = sba_pkg::BANDS_IN_DEF,
    parameter int COLUMNS_OUT = sba_pkg::COLUMNS_OUT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_band_value,
    // Output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [4:0] o_column,
    output logic [7:0] o_level,
    output logic       o_last_of_frame,
    // Configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    import sba_pkg::*;

    // Band store addressing and frame counters.
    localparam int AW     = $clog2(BANDS_IN);
    localparam int BW     = $clog2(BANDS_IN + 1);
    localparam int SUM_W  = $clog2(255 * BANDS_IN + 1);
    // Column indexing: COLUMNS_OUT itself marks the energy beat.
    localparam int COL_W  = $clog2(COLUMNS_OUT + 1);
    localparam int CAW    = (COLUMNS_OUT > 1) ? $clog2(COLUMNS_OUT) : 1;
    localparam int RS_W   = COL_W + 1;
    // Bin edges advance by BANDS_IN/COLUMNS_OUT with a carried remainder.
    localparam int BIN_Q  = BANDS_IN / COLUMNS_OUT;
    localparam int BIN_R  = BANDS_IN % COLUMNS_OUT;
    localparam int PROD_W = FRAC_W + LEVEL_W;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_count, n_count;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [LEVEL_W-1:0]   r_peak, n_peak;
    logic [LEVEL_W-1:0]   r_floor, n_floor;
    logic                 r_out_valid, n_out_valid;
    logic                 r_rd_vld, n_rd_vld;

    logic [LEVEL_W-1:0]   r_band_val, n_band_val;
    logic [LEVEL_W-1:0]   r_energy, n_energy;
    logic [COL_W-1:0]     r_col, n_col;
    logic [BW-1:0]        r_bin_q, n_bin_q;
    logic [COL_W-1:0]     r_bin_r, n_bin_r;
    logic [BW-1:0]        r_ptr, n_ptr;
    logic [SUM_W-1:0]     r_csum, n_csum;
    logic [BW-1:0]        r_ccnt, n_ccnt;
    logic [LEVEL_W-1:0]   r_mean, n_mean;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [COLUMN_W-1:0]  r_out_col, n_out_col;
    logic [LEVEL_W-1:0]   r_out_level, n_out_level;
    logic                 r_out_last, n_out_last;

    logic                 w_in_acc;
    logic                 w_last;
    logic [PROD_W-1:0]    w_prod;
    logic [LEVEL_W:0]     w_scaled_full;
    logic [LEVEL_W-1:0]   w_scaled;
    logic [RS_W-1:0]      w_rsum;
    logic [LEVEL_W-1:0]   w_x;

    logic                 band_wr_en;
    logic                 band_rd_en;
    logic [LEVEL_W-1:0]   band_rd_data;
    logic                 col_wr_en;
    logic                 col_rd_en;
    logic [LEVEL_W-1:0]   col_rd_data;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_last   = (r_col == COL_W'(COLUMNS_OUT));

    // Gain of about 1.0627: the band value itself plus its fractional product, then saturate.
    assign w_prod        = PROD_W'(r_band_val) * PROD_W'(SCALE_FRAC);
    assign w_scaled_full = {1'b0, r_band_val} + (LEVEL_W + 1)'(w_prod[PROD_W-1:FRAC_SHIFT]);
    assign w_scaled      = w_scaled_full[LEVEL_W] ? LEVEL_MAX : w_scaled_full[LEVEL_W-1:0];

    // Remainder step towards the next bin edge.
    assign w_rsum = RS_W'(r_bin_r) + RS_W'(BIN_R);

    // Value to be normalised: a stored column mean, or the energy on the final beat.
    assign w_x = w_last ? r_energy : col_rd_data;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_peak      = r_peak;
        n_floor     = r_floor;
        n_out_valid = r_out_valid;
        n_rd_vld    = r_rd_vld;
        n_band_val  = r_band_val;
        n_energy    = r_energy;
        n_col       = r_col;
        n_bin_q     = r_bin_q;
        n_bin_r     = r_bin_r;
        n_ptr       = r_ptr;
        n_csum      = r_csum;
        n_ccnt      = r_ccnt;
        n_mean      = r_mean;
        n_level     = r_level;
        n_out_col   = r_out_col;
        n_out_level = r_out_level;
        n_out_last  = r_out_last;

        band_wr_en       = 1'b0;
        band_rd_en       = 1'b0;
        col_wr_en        = 1'b0;
        col_rd_en        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_floor = i_cfg_data;
        end

        // The receiver has taken the pending beat.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_cmd == CMD_TICK) begin
                        if (r_peak > r_floor) begin
                            n_peak = r_peak - LEVEL_W'(1);
                        end
                    end else begin
                        n_band_val = i_band_value;
                        n_state    = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                band_wr_en = 1'b1;
                n_sum      = r_sum + SUM_W'(w_scaled);
                if (r_count == AW'(BANDS_IN - 1)) begin
                    n_count = '0;
                    n_state = ST_EDIV;
                end else begin
                    n_count = r_count + AW'(1);
                    n_state = ST_IDLE;
                end
            end
            ST_EDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_sum);
                div_req.divisor  = DIVR_W'(BANDS_IN);
                n_sum            = '0;
                n_bin_q          = '0;
                n_bin_r          = '0;
                n_ptr            = '0;
                n_col            = '0;
                n_state          = ST_EWAIT;
            end
            ST_EWAIT: begin
                if (div_rsp.done) begin
                    n_energy = div_rsp.quotient[LEVEL_W-1:0];
                    n_state  = ST_BIN_INIT;
                end
            end
            ST_BIN_INIT: begin
                if (w_rsum >= RS_W'(COLUMNS_OUT)) begin
                    n_bin_r = COL_W'(w_rsum - RS_W'(COLUMNS_OUT));
                    n_bin_q = r_bin_q + BW'(BIN_Q + 1);
                end else begin
                    n_bin_r = COL_W'(w_rsum);
                    n_bin_q = r_bin_q + BW'(BIN_Q);
                end
                n_csum   = '0;
                n_ccnt   = '0;
                n_rd_vld = 1'b0;
                n_state  = ST_BIN_WALK;
            end
            ST_BIN_WALK: begin
                if (r_ptr != r_bin_q) begin
                    band_rd_en = 1'b1;
                    n_ptr      = r_ptr + BW'(1);
                    n_rd_vld   = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    n_csum = r_csum + SUM_W'(band_rd_data);
                    n_ccnt = r_ccnt + BW'(1);
                end
                if (r_ptr == r_bin_q && !r_rd_vld) begin
                    if (r_ccnt == '0) begin
                        // An empty bin has a mean of zero.
                        n_mean  = '0;
                        n_state = ST_MEAN_WR;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(r_csum);
                        div_req.divisor  = DIVR_W'(r_ccnt);
                        n_state          = ST_MEAN_WAIT;
                    end
                end
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    n_mean  = div_rsp.quotient[LEVEL_W-1:0];
                    n_state = ST_MEAN_WR;
                end
            end
            ST_MEAN_WR: begin
                col_wr_en = 1'b1;
                if (r_mean > r_peak) begin
                    n_peak = r_mean;
                end
                if (r_col == COL_W'(COLUMNS_OUT - 1)) begin
                    n_col   = '0;
                    n_state = ST_NORM_RD;
                end else begin
                    n_col   = r_col + COL_W'(1);
                    n_state = ST_BIN_INIT;
                end
            end
            ST_NORM_RD: begin
                col_rd_en = !w_last;
                n_state   = ST_NORM_GO;
            end
            ST_NORM_GO: begin
                if (r_peak == '0) begin
                    // A peak that has decayed to zero gives full scale for any non-zero value.
                    n_level = (w_x != '0) ? LEVEL_MAX : '0;
                    n_state = ST_PUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = (DIV_W'(w_x) << LEVEL_W) - DIV_W'(w_x);
                    div_req.divisor  = r_peak;
                    n_state          = ST_NORM_WAIT;
                end
            end
            ST_NORM_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > DIV_W'(LEVEL_MAX)) begin
                        n_level = LEVEL_MAX;
                    end else begin
                        n_level = div_rsp.quotient[LEVEL_W-1:0];
                    end
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_col   = COLUMN_W'(r_col);
                    n_out_level = r_level;
                    n_out_last  = w_last;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + COL_W'(1);
                        n_state = ST_NORM_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_peak      <= PEAK_RESET;
            r_floor     <= PEAK_RESET;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_peak      <= n_peak;
            r_floor     <= n_floor;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_band_val  <= n_band_val;
        r_energy    <= n_energy;
        r_col       <= n_col;
        r_bin_q     <= n_bin_q;
        r_bin_r     <= n_bin_r;
        r_ptr       <= n_ptr;
        r_csum      <= n_csum;
        r_ccnt      <= n_ccnt;
        r_mean      <= n_mean;
        r_level     <= n_level;
        r_out_col   <= n_out_col;
        r_out_level <= n_out_level;
        r_out_last  <= n_out_last;
    end

    // Scaled bands of the current frame.
    sba_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (BANDS_IN)
    ) u_band_ram (
        .i_clk     (i_clk),
        .i_wr_en   (band_wr_en),
        .i_wr_addr (r_count),
        .i_wr_data (w_scaled),
        .i_rd_en   (band_rd_en),
        .i_rd_addr (r_ptr[AW-1:0]),
        .o_rd_data (band_rd_data)
    );

    // Column means of the frame being emitted.
    sba_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (COLUMNS_OUT)
    ) u_col_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_wr_en),
        .i_wr_addr (r_col[CAW-1:0]),
        .i_wr_data (r_mean),
        .i_rd_en   (col_rd_en),
        .i_rd_addr (r_col[CAW-1:0]),
        .o_rd_data (col_rd_data)
    );

    sba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_column        = r_out_col;
    assign o_level         = r_out_level;
    assign o_last_of_frame = r_out_last;
    assign o_cfg_ready     = 1'b1;

    // The divider is never restarted while it is still iterating.
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // Only the energy beat closes a frame, and it carries the energy column number.
    a_last_is_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_frame) |-> (o_column == COLUMN_W'(COLUMNS_OUT)))
        else $error("frame closed on a column beat");

    // A tick above the floor lowers the peak by exactly one.
    a_tick_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd == CMD_TICK && r_peak > r_floor)
        |=> (r_peak == $past(r_peak) - LEVEL_W'(1)))
        else $error("peak decay step wrong");

endmodule

// ===== hdl/sba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module sba_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/sba_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, shared by the whole sequencer.
module sba_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sba_pkg::t_div_req i_req,
    output sba_pkg::t_div_rsp o_rsp
);

    import sba_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_dvs;

    logic              n_busy;
    logic              n_done;
    logic [STEP_W-1:0] n_cnt;
    logic [DIV_W-1:0]  n_quo;
    logic [DIVR_W-1:0] n_rem;
    logic [DIVR_W-1:0] n_dvs;

    logic [DIVR_W:0]   w_shift;
    logic              w_ge;

    // Partial remainder stays below the divisor, so one extra bit covers the shifted value.
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(DIV_W);
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_rem = w_ge ? DIVR_W'(w_shift - {1'b0, r_dvs}) : w_shift[DIVR_W-1:0];
            n_cnt = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
